@@ rtl/core/irpd_pkg.sv @@
package irpd_pkg;

    localparam int FRAME_EDGES = 35;

    localparam int INTERVAL_W  = 24;
    localparam int CODE_W      = 32;
    localparam int INDEX_W     = 5;
    localparam int EDGE_W      = 6;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [EDGE_W-1:0] EDGE_MAX       = {EDGE_W{1'b1}};
    localparam logic [EDGE_W-1:0] FIRST_BIT_EDGE = EDGE_W'(2);
    localparam logic [EDGE_W-1:0] LAST_BIT_EDGE  = EDGE_W'(33);
    localparam logic [EDGE_W-1:0] FRAME_EDGE     = EDGE_W'(FRAME_EDGES);

    localparam int KEY_COUNT = 21;
    localparam logic [INDEX_W-1:0] UNKNOWN_KEY = INDEX_W'(KEY_COUNT);

    localparam logic [1:0] REG_FRAME_GAP     = 2'd0;
    localparam logic [1:0] REG_BIT_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_REPEAT_GAP    = 2'd2;

    localparam logic [INTERVAL_W-1:0] FRAME_GAP_RST     = INTERVAL_W'(200000);
    localparam logic [INTERVAL_W-1:0] BIT_THRESHOLD_RST = INTERVAL_W'(1800);
    localparam logic [INTERVAL_W-1:0] REPEAT_GAP_RST    = INTERVAL_W'(80000);

    localparam logic [CODE_W-1:0] KNOWN_CODES [KEY_COUNT] = '{
        32'hFFA25D, 32'hFF629D, 32'hFFE21D, 32'hFF22DD, 32'hFF02FD, 32'hFFC23D,
        32'hFFE01F, 32'hFFA857, 32'hFF906F, 32'hFF6897, 32'hFF9867, 32'hFFB04F,
        32'hFF30CF, 32'hFF18E7, 32'hFF7A85, 32'hFF10EF, 32'hFF38C7, 32'hFF5AA5,
        32'hFF42BD, 32'hFF4AB5, 32'hFF52AD
    };

    typedef struct packed {
        logic [INTERVAL_W-1:0] frame_gap_us;
        logic [INTERVAL_W-1:0] bit_threshold_us;
        logic [INTERVAL_W-1:0] repeat_gap_us;
    } t_cfg;

    function automatic logic [INDEX_W-1:0] lookup_key(input logic [CODE_W-1:0] code);
        logic [INDEX_W-1:0] idx;
        idx = UNKNOWN_KEY;
        for (int i = KEY_COUNT - 1; i >= 0; i--) begin
            if (KNOWN_CODES[i] == code) begin
                idx = INDEX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/core/irpd_cfg_regs.sv @@
module irpd_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [irpd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [irpd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [irpd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output irpd_pkg::t_cfg                    o_cfg
);

    irpd_pkg::t_cfg r_cfg;
    logic [1:0]     w_index;
    logic           w_write;

    assign w_index = paddr[3:2];
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_gap_us     <= irpd_pkg::FRAME_GAP_RST;
            r_cfg.bit_threshold_us <= irpd_pkg::BIT_THRESHOLD_RST;
            r_cfg.repeat_gap_us    <= irpd_pkg::REPEAT_GAP_RST;
        end else if (w_write) begin
            case (w_index)
                irpd_pkg::REG_FRAME_GAP: begin
                    r_cfg.frame_gap_us <= pwdata[irpd_pkg::INTERVAL_W-1:0];
                end
                irpd_pkg::REG_BIT_THRESHOLD: begin
                    r_cfg.bit_threshold_us <= pwdata[irpd_pkg::INTERVAL_W-1:0];
                end
                irpd_pkg::REG_REPEAT_GAP: begin
                    r_cfg.repeat_gap_us <= pwdata[irpd_pkg::INTERVAL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_index)
            irpd_pkg::REG_FRAME_GAP: begin
                prdata = irpd_pkg::APB_DATA_W'(r_cfg.frame_gap_us);
            end
            irpd_pkg::REG_BIT_THRESHOLD: begin
                prdata = irpd_pkg::APB_DATA_W'(r_cfg.bit_threshold_us);
            end
            irpd_pkg::REG_REPEAT_GAP: begin
                prdata = irpd_pkg::APB_DATA_W'(r_cfg.repeat_gap_us);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

@@ rtl/core/irpd_decode.sv @@
module irpd_decode (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  irpd_pkg::t_cfg                    i_cfg,
    input  logic                              i_take,
    input  logic                              i_advance,
    input  logic [irpd_pkg::INTERVAL_W-1:0]   i_interval_us,
    output logic                              o_load,
    output logic [irpd_pkg::EDGE_W-1:0]       o_edge_count,
    output logic                              o_out_valid,
    output logic [irpd_pkg::CODE_W-1:0]       o_key_code,
    output logic [irpd_pkg::INDEX_W-1:0]      o_key_index,
    output logic                              o_is_repeat
);

    logic [irpd_pkg::EDGE_W-1:0]  r_edge_count, n_edge_count;
    logic [irpd_pkg::CODE_W-1:0]  r_bit_shift,  n_bit_shift;
    logic [irpd_pkg::CODE_W-1:0]  r_last_code,  n_last_code;
    logic                         r_out_valid;
    logic [irpd_pkg::CODE_W-1:0]  r_key_code;
    logic [irpd_pkg::INDEX_W-1:0] r_key_index;
    logic                         r_is_repeat;

    logic                         w_restart;
    logic [irpd_pkg::EDGE_W-1:0]  w_count;
    logic [irpd_pkg::CODE_W-1:0]  w_shift_base;
    logic                         w_fresh;
    logic                         w_repeat;
    logic [irpd_pkg::CODE_W-1:0]  w_code;

    always_comb begin
        w_restart    = i_interval_us > i_cfg.frame_gap_us;
        w_count      = w_restart ? '0 : r_edge_count;
        w_shift_base = w_restart ? '0 : r_bit_shift;

        n_bit_shift = w_shift_base;
        if (w_count >= irpd_pkg::FIRST_BIT_EDGE && w_count <= irpd_pkg::LAST_BIT_EDGE) begin
            n_bit_shift = {w_shift_base[irpd_pkg::CODE_W-2:0],
                           i_interval_us > i_cfg.bit_threshold_us};
        end

        w_fresh  = w_count == irpd_pkg::FRAME_EDGE;
        w_repeat = w_count > irpd_pkg::FRAME_EDGE && i_interval_us > i_cfg.repeat_gap_us;
        w_code   = w_fresh ? n_bit_shift : r_last_code;

        n_last_code  = w_code;
        n_edge_count = (w_count == irpd_pkg::EDGE_MAX) ? w_count
                                                       : w_count + irpd_pkg::EDGE_W'(1);
    end

    assign o_load       = i_take && (w_fresh || w_repeat);
    assign o_edge_count = r_edge_count;
    assign o_out_valid  = r_out_valid;
    assign o_key_code   = r_key_code;
    assign o_key_index  = r_key_index;
    assign o_is_repeat  = r_is_repeat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_count <= '0;
            r_bit_shift  <= '0;
            r_last_code  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_take) begin
                r_edge_count <= n_edge_count;
                r_bit_shift  <= n_bit_shift;
                r_last_code  <= n_last_code;
            end
            if (i_advance) begin
                r_out_valid <= o_load;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_key_code  <= w_code;
            r_key_index <= irpd_pkg::lookup_key(w_code);
            r_is_repeat <= !w_fresh;
        end
    end

endmodule

@@ rtl/core/ir_remote_pulse_distance_decoder_core.sv @@
// An accepted edge word passes the input register and then the result register to its result word.
// Throughput: one edge word per cycle while the output does not stall; the edge and frame state update in one pass.
// The input register and the result register hold the data paths apart; an output
// stall reaches the input stall in the same cycle while the input register holds a word.
// Reset (synchronous, active low) clears edge count, shift and last code,
// empties both registers and restores the configuration defaults.
module ir_remote_pulse_distance_decoder_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [irpd_pkg::INTERVAL_W-1:0]   i_interval_us,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [irpd_pkg::CODE_W-1:0]       o_key_code,
    output logic [irpd_pkg::INDEX_W-1:0]      o_key_index,
    output logic                              o_is_repeat,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [irpd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [irpd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [irpd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    irpd_pkg::t_cfg                      w_cfg;
    logic                                r_s1_valid;
    logic [irpd_pkg::INTERVAL_W-1:0]     r_s1_interval;
    logic                                w_advance;
    logic                                w_take;
    logic                                w_load;
    logic [irpd_pkg::EDGE_W-1:0]         w_edge_count;

    irpd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_advance  = !o_out_valid || !i_out_stall;
    assign w_take     = r_s1_valid && w_advance;
    assign o_in_stall = r_s1_valid && !w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_interval <= i_interval_us;
        end
    end

    irpd_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_take        (w_take),
        .i_advance     (w_advance),
        .i_interval_us (r_s1_interval),
        .o_load        (w_load),
        .o_edge_count  (w_edge_count),
        .o_out_valid   (o_out_valid),
        .o_key_code    (o_key_code),
        .o_key_index   (o_key_index),
        .o_is_repeat   (o_is_repeat)
    );

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_key_index <= irpd_pkg::UNKNOWN_KEY)
        else $error("key index out of range");

    a_fresh_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_is_repeat || w_edge_count == irpd_pkg::FRAME_EDGE + irpd_pkg::EDGE_W'(1))
        else $error("fresh frame reported away from the last frame edge");

    a_repeat_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> !o_is_repeat || w_edge_count > irpd_pkg::FRAME_EDGE + irpd_pkg::EDGE_W'(1)
                   || w_edge_count == irpd_pkg::EDGE_MAX)
        else $error("repeat reported inside a frame");

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && o_out_valid)
        else $error("input stalled with nothing held");

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IV_MAX         = (1 << irpd_pkg::INTERVAL_W) - 1;
    localparam int unsigned DATA_FIRST     = 2;
    localparam int unsigned DATA_LAST      = 33;
    localparam int unsigned EDGE_SAT       = 63;
    localparam int unsigned KEY_TOTAL      = 21;
    localparam logic [irpd_pkg::INDEX_W-1:0] UNKNOWN_SLOT = irpd_pkg::INDEX_W'(21);
    localparam int unsigned DEF_FRAME_GAP  = 200000;
    localparam int unsigned DEF_BIT_THR    = 1800;
    localparam int unsigned DEF_REP_GAP    = 80000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    localparam logic [KEY_TOTAL*irpd_pkg::CODE_W-1:0] KEY_TABLE = {
        32'h00FFA25D, 32'h00FF629D, 32'h00FFE21D, 32'h00FF22DD, 32'h00FF02FD,
        32'h00FFC23D, 32'h00FFE01F, 32'h00FFA857, 32'h00FF906F, 32'h00FF6897,
        32'h00FF9867, 32'h00FFB04F, 32'h00FF30CF, 32'h00FF18E7, 32'h00FF7A85,
        32'h00FF10EF, 32'h00FF38C7, 32'h00FF5AA5, 32'h00FF42BD, 32'h00FF4AB5,
        32'h00FF52AD
    };

    typedef struct packed {
        logic [irpd_pkg::CODE_W-1:0]  code;
        logic [irpd_pkg::INDEX_W-1:0] slot;
        logic                         rpt;
    } t_key_report;

    logic                              i_clk         = 1'b0;
    logic                              i_rst_n       = 1'b0;
    logic                              i_in_valid    = 1'b0;
    logic                              o_in_stall;
    logic [irpd_pkg::INTERVAL_W-1:0]   i_interval_us = '0;
    logic                              o_out_valid;
    logic                              i_out_stall   = 1'b0;
    logic [irpd_pkg::CODE_W-1:0]       o_key_code;
    logic [irpd_pkg::INDEX_W-1:0]      o_key_index;
    logic                              o_is_repeat;
    logic                              psel          = 1'b0;
    logic                              penable       = 1'b0;
    logic                              pwrite        = 1'b0;
    logic [irpd_pkg::APB_ADDR_W-1:0]   paddr         = '0;
    logic [irpd_pkg::APB_DATA_W-1:0]   pwdata        = '0;
    logic [irpd_pkg::APB_DATA_W-1:0]   prdata;
    logic                              pready;

    // decoder state as the block should hold it
    int unsigned frame_gap = DEF_FRAME_GAP;
    int unsigned bit_thr   = DEF_BIT_THR;
    int unsigned rep_gap   = DEF_REP_GAP;
    int unsigned edge_idx  = 0;
    logic [irpd_pkg::CODE_W-1:0] shift_bits = '0;
    logic [irpd_pkg::CODE_W-1:0] last_code  = '0;

    t_key_report report_q[$];

    bit          idle_en      = 1'b1;
    int unsigned n_sent       = 0;
    int unsigned n_reports    = 0;
    int unsigned n_repeats    = 0;
    int unsigned n_settings   = 1;
    int unsigned err_count    = 0;
    int unsigned quiet_cycles = 0;

    ir_remote_pulse_distance_decoder_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_interval_us (i_interval_us),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_key_code    (o_key_code),
        .o_key_index   (o_key_index),
        .o_is_repeat   (o_is_repeat),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= idle_en && ($urandom_range(0, 99) < 38);
    end

    function automatic logic [irpd_pkg::CODE_W-1:0] key_at(input int unsigned k);
        return KEY_TABLE[(KEY_TOTAL - 1 - k) * irpd_pkg::CODE_W +: irpd_pkg::CODE_W];
    endfunction

    function automatic logic [irpd_pkg::INDEX_W-1:0] key_slot(
        input logic [irpd_pkg::CODE_W-1:0] code);
        logic [irpd_pkg::INDEX_W-1:0] slot;
        slot = UNKNOWN_SLOT;
        for (int k = 0; k < KEY_TOTAL; k++) begin
            if (slot == UNKNOWN_SLOT && key_at(k) == code) begin
                slot = irpd_pkg::INDEX_W'(k);
            end
        end
        return slot;
    endfunction

    function automatic void predict_edge(input int unsigned iv);
        t_key_report rep;
        if (iv > frame_gap) begin
            edge_idx   = 0;
            shift_bits = '0;
        end
        if (edge_idx >= DATA_FIRST && edge_idx <= DATA_LAST) begin
            shift_bits = {shift_bits[irpd_pkg::CODE_W-2:0], iv > bit_thr};
        end
        if (edge_idx == irpd_pkg::FRAME_EDGES) begin
            last_code = shift_bits;
            rep.code  = last_code;
            rep.slot  = key_slot(last_code);
            rep.rpt   = 1'b0;
            report_q.push_back(rep);
        end else if (edge_idx > irpd_pkg::FRAME_EDGES && iv > rep_gap) begin
            rep.code = last_code;
            rep.slot = key_slot(last_code);
            rep.rpt  = 1'b1;
            report_q.push_back(rep);
        end
        if (edge_idx < EDGE_SAT) begin
            edge_idx++;
        end
    endfunction

    function automatic int unsigned pick_range(input int unsigned lo, input int unsigned hi);
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0) begin
            return lo;
        end
        if (r == 1) begin
            return hi;
        end
        return $urandom_range(hi, lo);
    endfunction

    function automatic int unsigned min_of(input int unsigned a, input int unsigned b);
        return (a < b) ? a : b;
    endfunction

    function automatic int unsigned restart_iv();
        if (frame_gap >= IV_MAX) begin
            return IV_MAX;
        end
        return pick_range(frame_gap + 1, IV_MAX);
    endfunction

    function automatic int unsigned in_frame_iv();
        return pick_range(0, frame_gap);
    endfunction

    function automatic int unsigned data_iv(input logic one);
        if (one && bit_thr < frame_gap) begin
            return pick_range(bit_thr + 1, frame_gap);
        end
        return pick_range(0, min_of(bit_thr, frame_gap));
    endfunction

    function automatic int unsigned tail_iv(input logic want_rpt);
        if (want_rpt && rep_gap < frame_gap) begin
            return pick_range(rep_gap + 1, frame_gap);
        end
        return pick_range(0, min_of(rep_gap, frame_gap));
    endfunction

    function automatic logic [irpd_pkg::CODE_W-1:0] pick_code();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3, 4, 5, 6: return key_at($urandom_range(0, KEY_TOTAL - 1));
            7: return key_at($urandom_range(0, KEY_TOTAL - 1)) ^ (32'h1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_edge(input int unsigned iv);
        if (idle_en && $urandom_range(0, 99) < 38) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 38);
        end
        i_in_valid    <= 1'b1;
        i_interval_us <= irpd_pkg::INTERVAL_W'(iv);
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predict_edge(iv);
        n_sent++;
    endtask

    task automatic send_frame(input logic [irpd_pkg::CODE_W-1:0] code, input int unsigned tail);
        send_edge(restart_iv());
        send_edge(in_frame_iv());
        for (int b = irpd_pkg::CODE_W - 1; b >= 0; b--) begin
            send_edge(data_iv(code[b]));
        end
        send_edge(in_frame_iv());
        send_edge(in_frame_iv());
        repeat (tail) send_edge(tail_iv(1'($urandom_range(0, 1))));
    endtask

    task automatic send_broken_frame();
        int unsigned cut;
        cut = $urandom_range(1, DATA_LAST);
        send_edge(restart_iv());
        repeat (cut) begin
            if ($urandom_range(0, 1)) begin
                send_edge(in_frame_iv());
            end else begin
                send_edge(data_iv(1'($urandom_range(0, 1))));
            end
        end
    endtask

    task automatic send_noise();
        int unsigned base;
        case ($urandom_range(0, 3))
            0: base = frame_gap;
            1: base = bit_thr;
            2: base = rep_gap;
            default: base = $urandom_range(0, IV_MAX);
        endcase
        if (base < IV_MAX && $urandom_range(0, 1)) begin
            base++;
        end
        send_edge(base);
    endtask

    task automatic drain_block();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (report_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int unsigned val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= irpd_pkg::APB_DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            irpd_pkg::REG_FRAME_GAP:     frame_gap = val & IV_MAX;
            irpd_pkg::REG_BIT_THRESHOLD: bit_thr   = val & IV_MAX;
            irpd_pkg::REG_REPEAT_GAP:    rep_gap   = val & IV_MAX;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input int unsigned gap, input int unsigned thr,
                                  input int unsigned rgap);
        drain_block();
        write_reg(irpd_pkg::REG_FRAME_GAP, gap);
        write_reg(irpd_pkg::REG_BIT_THRESHOLD, thr);
        write_reg(irpd_pkg::REG_REPEAT_GAP, rgap);
        n_settings++;
    endtask

    task automatic test_random_traffic(input int unsigned n);
        int unsigned stop_at;
        int unsigned kind;
        stop_at = n_sent + n;
        while (n_sent < stop_at) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                send_frame(pick_code(), ($urandom_range(0, 9) == 0) ?
                           $urandom_range(20, 34) : $urandom_range(0, 6));
            end else if (kind < 82) begin
                send_broken_frame();
            end else begin
                send_noise();
            end
        end
    endtask

    task automatic test_interval_extremes();
        send_edge(0);
        send_edge(IV_MAX);
        send_edge(frame_gap);
        send_edge(frame_gap + 1);
        send_edge(bit_thr);
        send_edge(bit_thr + 1);
        send_edge(rep_gap);
        send_edge(rep_gap + 1);
        send_edge(32'h0055_5555);
        send_edge(32'h00AA_AAAA);
    endtask

    task automatic test_known_frame_and_repeat();
        send_frame(key_at(0), 0);
        // ties on the repeat gap stay silent, one above repeats
        send_edge(rep_gap);
        send_edge(rep_gap + 1);
        send_edge(0);
        send_edge(frame_gap);
    endtask

    task automatic test_unknown_code();
        send_frame('1, 0);
        send_edge(rep_gap + 1);
        send_frame('0, 1);
    endtask

    task automatic test_counter_saturation();
        send_frame(key_at(KEY_TOTAL - 1), 0);
        repeat (34) send_edge(tail_iv(1'($urandom_range(0, 1))));
    endtask

    task automatic test_register_settings();
        apply_settings(5000, 1000, 3000);
        test_random_traffic(110);
        apply_settings(IV_MAX, 0, 0);
        test_random_traffic(90);
        apply_settings(0, IV_MAX, IV_MAX);
        test_random_traffic(110);
        // repeat gap above frame gap: restart wins, no repeat
        apply_settings(20000, 20000, 50000);
        test_random_traffic(110);
        apply_settings($urandom_range(1000, 300000), $urandom_range(0, 5000),
                       $urandom_range(0, 300000));
        test_random_traffic(110);
        apply_settings(DEF_FRAME_GAP, DEF_BIT_THR, DEF_REP_GAP);
        test_random_traffic(60);
    endtask

    always @(posedge i_clk) begin : check_reports
        t_key_report want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (report_q.size() == 0) begin
                err_count++;
                if (err_count <= 10) begin
                    $display("unexpected key report: code %h index %0d repeat %0b",
                             o_key_code, o_key_index, o_is_repeat);
                end
            end else begin
                want = report_q.pop_front();
                n_reports++;
                if (want.rpt) begin
                    n_repeats++;
                end
                if (o_key_code !== want.code || o_key_index !== want.slot ||
                    o_is_repeat !== want.rpt) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("key report mismatch: code %h/%h index %0d/%0d repeat %0b/%0b",
                                 want.code, o_key_code, want.slot, o_key_index,
                                 want.rpt, o_is_repeat);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && i_out_stall === 1'b0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles without a word, %0d reports pending",
                     quiet_cycles, report_q.size());
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_interval_extremes();
        test_known_frame_and_repeat();
        test_unknown_code();
        test_counter_saturation();
        // hold both sides busy for a while
        idle_en = 1'b0;
        test_random_traffic(150);
        idle_en = 1'b1;
        test_random_traffic(70);
        test_register_settings();
        drain_block();
        if (report_q.size() != 0) begin
            err_count++;
            $display("%0d key reports never arrived", report_q.size());
        end
        $display("sent %0d edge words, checked %0d key reports (%0d repeats)",
                 n_sent, n_reports, n_repeats);
        $display("%0d register settings, random idle and stall on both channels",
                 n_settings);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/irpd_pkg.sv
rtl/core/irpd_cfg_regs.sv
rtl/core/irpd_decode.sv
rtl/core/ir_remote_pulse_distance_decoder_core.sv
tb/sv/tb_top.sv
